// ===== sv/min_heap_priority_queue_defines.svh =====
// Assertion macros for the min-heap priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mhpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [1:0]              t_status;
    typedef logic                    t_func;

    localparam t_func   FN_INSERT  = 1'b0;
    localparam t_func   FN_EXTRACT = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam t_key KEY_NONE = -32'sd1;

    typedef struct packed {
        logic ins;
        logic ext;
        t_key key;
    } t_cell_ctl;

endpackage

// ===== sv/mhpq_ifs.sv =====
// Request and response channel interfaces of the min-heap priority queue.
interface mhpq_req_if;
    logic                      valid;
    logic                      ready;
    mhpq_pkg::t_func           func;
    mhpq_pkg::t_key            key_in;

    modport source (output valid, output func, output key_in, input ready);
    modport sink   (input valid, input func, input key_in, output ready);
endinterface

interface mhpq_rsp_if;
    logic                      valid;
    logic                      ready;
    mhpq_pkg::t_key            key_out;
    mhpq_pkg::t_status         status;

    modport source (output valid, output key_out, output status, input ready);
    modport sink   (input valid, input key_out, input status, output ready);
endinterface

// ===== sv/min_heap_priority_queue.sv =====
// The response to an accepted request is held in the output register from the next cycle on.
// Throughput: one item per cycle while the response side keeps taking results.
// Keys live in a chain of DEPTH-1 cells kept in ascending order; an insert or extract
// updates every cell in the same cycle, so no operation walks the levels.
// Reset clears the key count and the output valid; cell contents stay undefined.
module min_heap_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);
    import mhpq_pkg::*;

    `include "min_heap_priority_queue_defines.svh"

    localparam int N  = DEPTH - 1;
    localparam int CW = $clog2(DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_ovalid;
    t_key          r_key_out;
    t_status       r_status;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_do_ins;
    logic      w_do_ext;
    t_cell_ctl w_ctl;
    t_key      w_key [N];
    logic      w_gt  [N];

    assign i_req.ready = !r_ovalid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = r_count == CW'(N);
    assign w_empty     = r_count == '0;
    assign w_do_ins    = w_accept && (i_req.func == FN_INSERT) && !w_full;
    assign w_do_ext    = w_accept && (i_req.func == FN_EXTRACT) && !w_empty;

    assign w_ctl = '{ins: w_do_ins, ext: w_do_ext, key: i_req.key_in};

    for (genvar g = 0; g < N; g++) begin : g_cell
        mhpq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left_key  ((g == 0) ? KEY_NONE : w_key[(g == 0) ? 0 : g - 1]),
            .i_left_gt   ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_right_key ((g == N - 1) ? KEY_NONE : w_key[(g == N - 1) ? g : g + 1]),
            .o_key       (w_key[g]),
            .o_gt        (w_gt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_do_ext) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (i_req.func)
                FN_INSERT: begin
                    r_key_out <= '0;
                    r_status  <= w_full ? ST_FULL : ST_OK;
                end
                FN_EXTRACT: begin
                    r_key_out <= w_empty ? KEY_NONE : w_key[0];
                    r_status  <= w_empty ? ST_EMPTY : ST_OK;
                end
                default: begin
                    r_key_out <= '0;
                    r_status  <= ST_OK;
                end
            endcase
        end
    end

    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.key_out = r_key_out;
    assign o_rsp.status  = r_status;

    `MHPQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, w_do_ins,
        r_count == $past(r_count) + CW'(1), "insert did not advance count")
    `MHPQ_ASSERT_NEXT(a_ext_head, i_clk, i_rst_n, w_do_ext,
        (r_key_out == $past(w_key[0])) && (r_status == ST_OK),
        "extract did not return head key")
    `MHPQ_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n,
        w_accept && (i_req.func == FN_INSERT) && w_full,
        (r_status == ST_FULL) && $stable(r_count), "full insert changed state")
    `MHPQ_ASSERT_NOW(a_ext_nonempty, i_clk, i_rst_n, w_do_ext, r_count != '0,
        "extract from empty chain")

endmodule

// ===== sv/mhpq_cell.sv =====
// One slot of the sorted key chain: holds a key, shifts or inserts with its neighbors.
module mhpq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  logic                i_clk,
    input  mhpq_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_count,
    input  mhpq_pkg::t_key      i_left_key,
    input  logic                i_left_gt,
    input  mhpq_pkg::t_key      i_right_key,
    output mhpq_pkg::t_key      o_key,
    output logic                o_gt
);
    import mhpq_pkg::*;

    t_key r_key;
    t_key n_key;
    logic w_valid;
    logic w_in_range;

    assign w_valid    = CW'(IDX) < i_count;
    assign w_in_range = CW'(IDX) <= i_count;
    assign o_gt       = w_valid && (r_key > i_ctl.key);
    assign o_key      = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ext) begin
            n_key = i_right_key;
        end else if (i_ctl.ins && w_in_range) begin
            if (i_left_gt) begin
                n_key = i_left_key;
            end else if (o_gt || !w_valid) begin
                n_key = i_ctl.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== tb/sv/min_heap_priority_queue_checker.sv =====
// Heap predictor and response checker for the min-heap priority queue testbench.
`timescale 1ns / 1ps

module min_heap_priority_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  mhpq_pkg::t_func   i_req_func,
    input  mhpq_pkg::t_key    i_req_key,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  mhpq_pkg::t_key    i_rsp_key,
    input  mhpq_pkg::t_status i_rsp_status,
    output int                o_fail_count,
    output int                o_pending
);
    import mhpq_pkg::*;

    typedef struct {
        t_key    key;
        t_status status;
    } t_heap_result;

    t_key         heap_slots [DEPTH];
    int           key_count;
    t_heap_result awaited_results [$];

    function automatic void swap_slots(input int a, input int b);
        t_key tmp;
        tmp = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = tmp;
    endfunction

    function automatic t_heap_result heap_apply(input t_func fn, input t_key key);
        t_heap_result res;
        int pos;
        int best;
        int lchild;
        int rchild;
        if (fn == FN_INSERT) begin
            res.key = '0;
            if (key_count >= DEPTH - 1) begin
                res.status = ST_FULL;
                return res;
            end
            key_count++;
            heap_slots[key_count] = key;
            pos = key_count;
            while (pos > 1 && heap_slots[pos] < heap_slots[pos / 2]) begin
                swap_slots(pos, pos / 2);
                pos = pos / 2;
            end
            res.status = ST_OK;
            return res;
        end
        if (key_count == 0) begin
            res.key    = KEY_NONE;
            res.status = ST_EMPTY;
            return res;
        end
        res.key    = heap_slots[1];
        res.status = ST_OK;
        heap_slots[1] = heap_slots[key_count];
        key_count--;
        pos = 1;
        forever begin
            best   = pos;
            lchild = 2 * pos;
            rchild = lchild + 1;
            if (lchild <= key_count && heap_slots[lchild] < heap_slots[best])
                best = lchild;
            if (rchild <= key_count && heap_slots[rchild] < heap_slots[best])
                best = rchild;
            if (best == pos)
                break;
            swap_slots(pos, best);
            pos = best;
        end
        return res;
    endfunction

    initial begin
        key_count    = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got key %0d status %0d",
                             $time, i_rsp_key, i_rsp_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp_key !== want.key || i_rsp_status !== want.status) begin
                        if (i_rsp_key !== want.key)
                            $display("%0t: key_out mismatch: expected %0d, got %0d",
                                     $time, want.key, i_rsp_key);
                        if (i_rsp_status !== want.status)
                            $display("%0t: status mismatch: expected %0d, got %0d",
                                     $time, want.status, i_rsp_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                awaited_results.push_back(heap_apply(i_req_func, i_req_key));
            o_pending <= awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/min_heap_priority_queue_test.sv =====
// Top of the min-heap priority queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module min_heap_priority_queue_test;
    import mhpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1825;
    localparam int HOLD_CYCLES  = 600;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    mhpq_req_if req ();
    mhpq_rsp_if rsp ();

    min_heap_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    min_heap_priority_queue_checker #(
        .DEPTH(DEPTH)
    ) checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req.valid),
        .i_req_ready  (req.ready),
        .i_req_func   (req.func),
        .i_req_key    (req.key_in),
        .i_rsp_valid  (rsp.valid),
        .i_rsp_ready  (rsp.ready),
        .i_rsp_key    (rsp.key_out),
        .i_rsp_status (rsp.status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(input t_func fn, input t_key key, input int gap);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid  <= 1'b1;
        req.func   <= fn;
        req.key_in <= key;
        do @(posedge i_clk); while (!(req.valid && req.ready));
        @(negedge i_clk);
    endtask

    function automatic t_key draw_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return t_key'($urandom);
        if (pick < 8)
            return t_key'(int'($urandom_range(0, 8)) - 4);
        if (pick == 8) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return '0;
                default: return KEY_NONE;
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            return t_key'(32'h80000000 + $urandom_range(0, 3));
        return t_key'(32'h7fffffff - $urandom_range(0, 3));
    endfunction

    initial begin
        rsp.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        begin
            int  taken;
            int  stall;
            bit  quiet;
            taken = 0;
            quiet = 1'b0;
            forever begin
                if (taken % 60 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                stall = quiet ? 0 : $urandom_range(0, 18);
                if (taken == 300)
                    stall = HOLD_CYCLES;
                if (stall > 0) begin
                    rsp.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                rsp.ready <= 1'b1;
                do @(posedge i_clk); while (!(rsp.valid && rsp.ready));
                taken++;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int    phase;
        bit    quiet;
        int    gap;
        t_func fn;
        t_key  fill_keys [15];

        req.valid  = 1'b0;
        req.func   = FN_INSERT;
        req.key_in = '0;
        i_rst_n    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fill_keys = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1,
                      32'sd5, 32'sd5, 32'sd5, -32'sd7, 32'sh80000000,
                      32'sh7fffffff, 32'sd3, 32'sd3, -32'sd2, 32'sd100};

        send_item(FN_EXTRACT, 32'sh5a5a5a5a, 0);
        foreach (fill_keys[i])
            send_item(FN_INSERT, fill_keys[i], $urandom_range(0, 2));
        send_item(FN_INSERT, 32'sd42, 0);
        repeat (8)
            send_item(FN_EXTRACT, t_key'($urandom), $urandom_range(0, 2));

        phase = 0;
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                phase = $urandom_range(0, 2);
                quiet = ($urandom_range(0, 2) == 0);
            end
            case (phase)
                0:       fn = ($urandom_range(0, 3) != 0) ? FN_INSERT : FN_EXTRACT;
                1:       fn = ($urandom_range(0, 3) != 0) ? FN_EXTRACT : FN_INSERT;
                default: fn = ($urandom_range(0, 1) != 0) ? FN_EXTRACT : FN_INSERT;
            endcase
            gap = quiet ? 0 : $urandom_range(0, 18);
            send_item(fn, draw_key(), gap);
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== min_heap_priority_queue.f =====
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_ifs.sv
sv/mhpq_cell.sv
sv/min_heap_priority_queue.sv
tb/sv/min_heap_priority_queue_checker.sv
tb/sv/min_heap_priority_queue_test.sv
